// ===== design/rls_pkg.sv =====
// Shared constants for the RGB LED strip serializer.
// No dependencies; imported by the top level and the pixel store.
package rls_pkg;

	// Default strip size
	localparam int MAX_LEDS_DEF = 64;

	// Field and register widths
	localparam int PIXEL_W     = 24;
	localparam int LED_COUNT_W = 7;
	localparam int TICK_W      = 16;
	localparam int FRAME_W     = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int MODE_W      = 2;
	localparam int LED_IDX_W   = 6;

	// Item modes
	localparam logic [MODE_W-1:0] MODE_TICK    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SET_ONE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SET_ALL = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_ZERO    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_ONE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD = 3'd4;

	// Reset values of the registers
	localparam logic [LED_COUNT_W-1:0] LED_COUNT_RST    = 7'd8;
	localparam logic [TICK_W-1:0]      HIGH_ZERO_RST    = 16'd2;
	localparam logic [TICK_W-1:0]      HIGH_ONE_RST     = 16'd5;
	localparam logic [TICK_W-1:0]      BIT_PERIOD_RST   = 16'd8;
	localparam logic [FRAME_W-1:0]     FRAME_PERIOD_RST = 32'd100000;

	// Byte order on the wire
	localparam logic [1:0] COL_GREEN = 2'd0;
	localparam logic [1:0] COL_RED   = 2'd1;
	localparam logic [1:0] COL_BLUE  = 2'd2;

	localparam logic [7:0] MSB_MASK = 8'h80;

endpackage

// ===== design/rls_pixel_store.sv =====
// Colour memory of the LED strip: one write port, one registered read port.
// Depends on rls_pkg for the pixel width.
module rls_pixel_store #(
	parameter int MAX_LEDS = rls_pkg::MAX_LEDS_DEF,
	parameter int IDX_W    = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [IDX_W-1:0]            wr_addr,
	input  logic [rls_pkg::PIXEL_W-1:0] wr_data,
	input  logic [IDX_W-1:0]            rd_addr,
	output logic [rls_pkg::PIXEL_W-1:0] rd_data
);
	import rls_pkg::*;

	logic [PIXEL_W-1:0] mem [MAX_LEDS];
	logic [MAX_LEDS-1:0] vld_q;
	logic [PIXEL_W-1:0] rd_q;
	logic               rd_vld_q;
	logic               wr_hit;

	assign wr_hit = wr_en && (wr_addr == rd_addr);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		// forward a write to the address being read
		if (wr_hit) begin
			rd_q <= wr_data;
		end else begin
			rd_q <= mem[rd_addr];
		end
	end

	// entries never written read as black
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rd_vld_q <= wr_hit || vld_q[rd_addr];
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

// ===== design/rgb_led_strip_serializer.sv =====
// Top level of the one-wire RGB LED strip serializer.
// Depends on rls_pkg and instantiates rls_pixel_store.

// Each accepted item gives one result. A tick item (mode 0) is one time unit
// of the line waveform, so ticks may stream at one per clock while results
// are taken and no set-all fill runs; line_level in its result is the data
// line level for that tick and sending is high while a frame goes out.
// Outside a frame, ticks count the frame timer down; when it is found at zero
// it reloads with frame_period_ticks and a pending refresh starts a frame in
// the same tick. A frame sends LEDs 0 to led_count-1 (saturated to MAX_LEDS),
// green, red, blue, MSB first; a bit is high for high_ticks_one or
// high_ticks_zero ticks out of bit_period_ticks. A set-one item (mode 1) is
// dropped when its index is not below the LED count. A set-all item (mode 2)
// is accepted, after which the input stays not ready while the single write
// port of the pixel memory fills LEDs 0 to the saturated count minus one;
// with a count of zero nothing is filled and the input stays ready. Mode 3 is
// ignored and repeats the held outputs. Results sit in an output register,
// and a new item is accepted in the cycle the previous result is taken,
// unless a set-all fill runs. Configuration is written through
// cfg_we/cfg_index/cfg_wdata at any edge, meant while the block is idle.
module rgb_led_strip_serializer #(
	parameter int MAX_LEDS = rls_pkg::MAX_LEDS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rls_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rls_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [rls_pkg::MODE_W-1:0]    mode,
	input  logic [rls_pkg::LED_IDX_W-1:0] led_index,
	input  logic [7:0]                    red,
	input  logic [7:0]                    green,
	input  logic [7:0]                    blue,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          line_level,
	output logic                          sending
);
	import rls_pkg::*;

	localparam int IDX_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
	localparam int CNT_W = $clog2(MAX_LEDS + 1);
	localparam int CMP_W = (CNT_W > LED_COUNT_W) ? CNT_W : LED_COUNT_W;

	// configuration registers
	logic [LED_COUNT_W-1:0] led_count_q;
	logic [TICK_W-1:0]      high_zero_q;
	logic [TICK_W-1:0]      high_one_q;
	logic [TICK_W-1:0]      bit_period_q;
	logic [FRAME_W-1:0]     frame_period_q;

	// frame state
	logic               pending_q, pending_d;
	logic [FRAME_W-1:0] timer_q, timer_d;
	logic               active_q, active_d;
	logic [IDX_W-1:0]   led_cur_q, led_cur_d;
	logic [1:0]         col_cur_q, col_cur_d;
	logic [2:0]         bit_cur_q, bit_cur_d;
	logic [TICK_W-1:0]  btc_q, btc_d;
	logic               line_q, line_d;

	// set-all fill
	logic               sweep_q;
	logic [IDX_W-1:0]   sweep_ptr_q;
	logic [CNT_W-1:0]   sweep_n_q;
	logic [PIXEL_W-1:0] sweep_col_q;
	logic               sweep_last;

	// result register
	logic out_valid_q;

	logic               accept;
	logic [CNT_W-1:0]   n_eff;
	logic               is_tick, is_one, is_all;
	logic               one_ok;
	logic               start, send;
	logic [PIXEL_W-1:0] pixel;
	logic [7:0]         byte_sel;
	logic               cur_bit;
	logic [TICK_W-1:0]  high_t, period_t, btc_inc;
	logic [CNT_W-1:0]   led_next;
	logic [PIXEL_W-1:0] in_colour;

	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	logic [PIXEL_W-1:0] wr_data;

	assign in_ready  = !sweep_q && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		if (CMP_W'(led_count_q) > CMP_W'(MAX_LEDS)) begin
			n_eff = CNT_W'(MAX_LEDS);
		end else begin
			n_eff = CNT_W'(led_count_q);
		end
	end

	assign is_tick   = accept && (mode == MODE_TICK);
	assign is_one    = accept && (mode == MODE_SET_ONE);
	assign is_all    = accept && (mode == MODE_SET_ALL);
	assign one_ok    = is_one && (CMP_W'(led_index) < CMP_W'(n_eff));
	assign in_colour = {red, green, blue};

	// a frame starts when the idle timer is found at zero with a refresh owed and a nonzero LED count
	assign start = !active_q && (timer_q == '0) && pending_q && (n_eff != '0);
	assign send  = is_tick && (active_q || start);

	// pick the byte, then the bit under the cursor
	always_comb begin
		unique case (col_cur_q)
			COL_GREEN: byte_sel = pixel[15:8];
			COL_RED:   byte_sel = pixel[23:16];
			default:   byte_sel = pixel[7:0];
		endcase
	end

	assign cur_bit  = |((byte_sel << bit_cur_q) & MSB_MASK);
	assign high_t   = cur_bit ? high_one_q : high_zero_q;
	assign period_t = (bit_period_q == '0) ? TICK_W'(1) : bit_period_q;
	assign btc_inc  = btc_q + TICK_W'(1);
	assign led_next = CNT_W'(led_cur_q) + CNT_W'(1);

	always_comb begin
		pending_d = pending_q;
		timer_d   = timer_q;
		active_d  = active_q;
		led_cur_d = led_cur_q;
		col_cur_d = col_cur_q;
		bit_cur_d = bit_cur_q;
		btc_d     = btc_q;
		line_d    = line_q;

		if (one_ok || is_all) begin
			pending_d = 1'b1;
		end

		if (is_tick && !active_q) begin
			line_d = 1'b0;
			if (timer_q != '0) begin
				timer_d = timer_q - FRAME_W'(1);
			end else begin
				timer_d = frame_period_q;
				if (pending_q) begin
					pending_d = 1'b0;
				end
			end
		end

		if (send) begin
			active_d = 1'b1;
			line_d   = (btc_q < high_t);
			btc_d    = btc_inc;
			// advance bit, then byte, then LED
			if (btc_inc >= period_t) begin
				btc_d = '0;
				priority if (bit_cur_q != 3'd7) begin
					bit_cur_d = bit_cur_q + 3'd1;
				end else if (col_cur_q != COL_BLUE) begin
					bit_cur_d = '0;
					col_cur_d = col_cur_q + 2'd1;
				end else begin
					bit_cur_d = '0;
					col_cur_d = COL_GREEN;
					if (led_next >= n_eff) begin
						led_cur_d = '0;
						active_d  = 1'b0;
					end else begin
						led_cur_d = led_next[IDX_W-1:0];
					end
				end
			end
		end
	end

	// fill port of the pixel memory: a set-one item writes at once, set-all sweeps
	always_comb begin
		if (sweep_q) begin
			wr_en   = 1'b1;
			wr_addr = sweep_ptr_q;
			wr_data = sweep_col_q;
		end else begin
			wr_en   = one_ok;
			wr_addr = IDX_W'(led_index);
			wr_data = in_colour;
		end
	end

	assign sweep_last = (CNT_W'(sweep_ptr_q) + CNT_W'(1)) == sweep_n_q;

	rls_pixel_store #(
		.MAX_LEDS(MAX_LEDS),
		.IDX_W   (IDX_W)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(led_cur_d),
		.rd_data(pixel)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_count_q    <= LED_COUNT_RST;
			high_zero_q    <= HIGH_ZERO_RST;
			high_one_q     <= HIGH_ONE_RST;
			bit_period_q   <= BIT_PERIOD_RST;
			frame_period_q <= FRAME_PERIOD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LED_COUNT:    led_count_q    <= cfg_wdata[LED_COUNT_W-1:0];
				CFG_HIGH_ZERO:    high_zero_q    <= cfg_wdata[TICK_W-1:0];
				CFG_HIGH_ONE:     high_one_q     <= cfg_wdata[TICK_W-1:0];
				CFG_BIT_PERIOD:   bit_period_q   <= cfg_wdata[TICK_W-1:0];
				CFG_FRAME_PERIOD: frame_period_q <= cfg_wdata[FRAME_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= 1'b1;
			timer_q     <= '0;
			active_q    <= 1'b0;
			led_cur_q   <= '0;
			col_cur_q   <= COL_GREEN;
			bit_cur_q   <= '0;
			btc_q       <= '0;
			line_q      <= 1'b0;
			sweep_q     <= 1'b0;
			sweep_ptr_q <= '0;
			sweep_n_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pending_q <= pending_d;
			timer_q   <= timer_d;
			active_q  <= active_d;
			led_cur_q <= led_cur_d;
			col_cur_q <= col_cur_d;
			bit_cur_q <= bit_cur_d;
			btc_q     <= btc_d;
			line_q    <= line_d;

			if (is_all && (n_eff != '0)) begin
				sweep_q     <= 1'b1;
				sweep_ptr_q <= '0;
				sweep_n_q   <= n_eff;
			end else if (sweep_q) begin
				if (sweep_last) begin
					sweep_q     <= 1'b0;
					sweep_ptr_q <= '0;
				end else begin
					sweep_ptr_q <= sweep_ptr_q + IDX_W'(1);
				end
			end

			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// colour of a set-all fill; held for the length of the sweep
	always_ff @(posedge clk) begin
		if (is_all) begin
			sweep_col_q <= in_colour;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (accept) begin
			line_level <= line_d;
			sending    <= active_d;
		end
	end

	// no item enters while the fill port is busy
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		sweep_q |-> !in_ready)
		else $error("item accepted during set-all fill");

	// cursors rest at zero between frames, which a frame start relies on
	a_idle_cursors: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> (led_cur_q == '0 && col_cur_q == COL_GREEN && bit_cur_q == '0
			&& btc_q == '0))
		else $error("cursor not at zero outside a frame");

	// the timer stays put while a frame is sent
	a_timer_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |=> $stable(timer_q))
		else $error("frame timer moved during a frame");

	// a sweep never runs past the LED count latched at its start
	a_sweep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sweep_q |-> (CNT_W'(sweep_ptr_q) < sweep_n_q))
		else $error("set-all fill past its count");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for rgb_led_strip_serializer: drives tick, set-one, set-all and
// ignored items and checks line_level and sending of every result against a built-in model.
// Depends on rls_pkg and the rgb_led_strip_serializer RTL.
module tb;
	import rls_pkg::*;

	localparam logic [MODE_W-1:0]    MODE_NONE    = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED   = 3'd7;
	localparam int                   FILL_WAIT    = 140;
	localparam int                   CYCLE_LIMIT  = 1000000;
	localparam int                   MAX_REPORTS  = 100;
	localparam int                   FRAME_GUARD  = 20000;

	typedef struct packed {
		logic line_level;
		logic sending;
	} strip_out_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	logic [MODE_W-1:0]     mode      = MODE_TICK;
	logic [LED_IDX_W-1:0]  led_index = '0;
	logic [7:0]            red       = '0;
	logic [7:0]            green     = '0;
	logic [7:0]            blue      = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  line_level;
	logic                  sending;

	rgb_led_strip_serializer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.led_index(led_index),
		.red(red),
		.green(green),
		.blue(blue),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.line_level(line_level),
		.sending(sending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Expected line level and sending flag, one entry per accepted item
	strip_out_t level_q[$];
	int         errors    = 0;
	int unsigned cycle_cnt = 0;

	// Traffic shaping shared with the receiver process
	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	int rx_hold = 0;

	// Strip model: configuration
	logic [LED_COUNT_W-1:0] c_count  = LED_COUNT_RST;
	logic [TICK_W-1:0]      c_hzero  = HIGH_ZERO_RST;
	logic [TICK_W-1:0]      c_hone   = HIGH_ONE_RST;
	logic [TICK_W-1:0]      c_period = BIT_PERIOD_RST;
	logic [FRAME_W-1:0]     c_frame  = FRAME_PERIOD_RST;

	// Strip model: state
	logic [PIXEL_W-1:0] m_pix [MAX_LEDS_DEF];
	logic               m_pending = 1'b1;
	logic [FRAME_W-1:0] m_timer   = '0;
	logic               m_active  = 1'b0;
	int                 m_led     = 0;
	logic [1:0]         m_col     = '0;
	logic [2:0]         m_bit     = '0;
	logic [TICK_W-1:0]  m_tcnt    = '0;
	logic               m_line    = 1'b0;

	initial begin
		for (int i = 0; i < MAX_LEDS_DEF; i++)
			m_pix[i] = '0;
	end

	function automatic int eff_count();
		return (c_count > MAX_LEDS_DEF) ? MAX_LEDS_DEF : int'(c_count);
	endfunction

	function automatic logic cur_bit();
		logic [PIXEL_W-1:0] px;
		logic [7:0]         byt;
		px = (m_led < MAX_LEDS_DEF) ? m_pix[m_led] : '0;
		case (m_col)
			COL_GREEN: byt = px[15:8];
			COL_RED:   byt = px[23:16];
			default:   byt = px[7:0];
		endcase
		return |((byt << m_bit) & MSB_MASK);
	endfunction

	// Drive one tick of the current bit, then step bit, byte and LED
	function automatic void bit_advance();
		logic [TICK_W-1:0] high;
		logic [TICK_W-1:0] per;
		high = cur_bit() ? c_hone : c_hzero;
		per = (c_period < 1) ? 16'd1 : c_period;
		m_line = (m_tcnt < high);
		m_tcnt = m_tcnt + 16'd1;
		if (m_tcnt < per)
			return;
		m_tcnt = '0;
		if (m_bit < 7) begin
			m_bit++;
			return;
		end
		m_bit = '0;
		if (m_col < 2) begin
			m_col++;
			return;
		end
		m_col = '0;
		m_led++;
		if (m_led >= eff_count()) begin
			m_led = 0;
			m_active = 1'b0;
		end
	endfunction

	function automatic void frame_tick();
		if (!m_active) begin
			if (m_timer != 0) begin
				m_timer--;
				m_line = 1'b0;
				return;
			end
			m_timer = c_frame;
			m_line = 1'b0;
			if (!m_pending)
				return;
			m_pending = 1'b0;
			if (eff_count() == 0)
				return;
			m_active = 1'b1;
			m_led = 0;
			m_col = '0;
			m_bit = '0;
			m_tcnt = '0;
		end
		bit_advance();
	endfunction

	function automatic strip_out_t strip_step(input logic [MODE_W-1:0] md,
			input logic [LED_IDX_W-1:0] idx, input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		strip_out_t res;
		int         n;
		n = eff_count();
		case (md)
			MODE_TICK: frame_tick();
			MODE_SET_ONE: begin
				if (idx < n) begin
					m_pix[idx] = {r, g, b};
					m_pending = 1'b1;
				end
			end
			MODE_SET_ALL: begin
				for (int i = 0; i < n; i++)
					m_pix[i] = {r, g, b};
				m_pending = 1'b1;
			end
			default: ;
		endcase
		res.line_level = m_line;
		res.sending = m_active;
		return res;
	endfunction

	// Offer one item, hold it until accepted, then record its expected result
	task automatic send_item(input logic [MODE_W-1:0] md, input logic [LED_IDX_W-1:0] idx,
			input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		if (tx_idle && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= md;
		led_index <= idx;
		red <= r;
		green <= g;
		blue <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		level_q.push_back(strip_step(md, idx, r, g, b));
	endtask

	task automatic push_tick();
		send_item(MODE_TICK, LED_IDX_W'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			CFG_LED_COUNT:    c_count = data[LED_COUNT_W-1:0];
			CFG_HIGH_ZERO:    c_hzero = data[TICK_W-1:0];
			CFG_HIGH_ONE:     c_hone = data[TICK_W-1:0];
			CFG_BIT_PERIOD:   c_period = data[TICK_W-1:0];
			CFG_FRAME_PERIOD: c_frame = data;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Stop offering items and wait for every expected result
	task automatic settle();
		in_valid <= 1'b0;
		while (level_q.size() != 0)
			@(posedge clk);
	endtask

	// Settle, then let a set-all fill run out before touching registers
	task automatic quiesce();
		settle();
		repeat (FILL_WAIT) @(posedge clk);
	endtask

	task automatic start_frame();
		int guard;
		guard = 0;
		while (!m_active && guard < FRAME_GUARD) begin
			push_tick();
			guard++;
		end
	endtask

	// Tick until any pending refresh has gone out and no frame is active
	task automatic finish_frames();
		int guard;
		guard = 0;
		while ((m_active || m_pending) && guard < FRAME_GUARD) begin
			push_tick();
			guard++;
		end
	endtask

	// Default timing, ignored items, and a frame cut short by a lower LED count
	task automatic test_reset_defaults();
		write_reg(CFG_FRAME_PERIOD, 32'd2);
		write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
		send_item(MODE_NONE, 6'd63, 8'hFF, 8'hFF, 8'hFF);
		send_item(MODE_SET_ONE, 6'd8, 8'h12, 8'h34, 8'h56);
		send_item(MODE_SET_ONE, 6'd0, 8'hFF, 8'h00, 8'hFF);
		send_item(MODE_SET_ONE, 6'd7, 8'h00, 8'hFF, 8'h00);
		repeat (20) push_tick();
		quiesce();
		write_reg(CFG_LED_COUNT, 32'd1);
		write_reg(CFG_BIT_PERIOD, 32'd1);
		// rewrite LED 0 while it is on the wire
		push_tick();
		send_item(MODE_SET_ONE, 6'd0, 8'h00, 8'hFF, 8'h00);
		send_item(MODE_NONE, 6'd0, 8'h00, 8'h00, 8'h00);
		finish_frames();
	endtask

	// High time of zero, high time past the period, and zero / largest bit periods
	task automatic test_bit_timing();
		quiesce();
		write_reg(CFG_HIGH_ZERO, 32'd0);
		write_reg(CFG_HIGH_ONE, 32'hFFFF);
		write_reg(CFG_BIT_PERIOD, 32'd3);
		send_item(MODE_SET_ONE, 6'd0, 8'hA5, 8'h5A, 8'h0F);
		finish_frames();
		quiesce();
		write_reg(CFG_HIGH_ZERO, 32'd1);
		write_reg(CFG_HIGH_ONE, 32'd2);
		write_reg(CFG_BIT_PERIOD, 32'd0);
		send_item(MODE_SET_ALL, LED_IDX_W'($urandom), 8'h00, 8'hFF, 8'h81);
		start_frame();
		quiesce();
		write_reg(CFG_BIT_PERIOD, 32'hFFFF);
		repeat (12) push_tick();
		quiesce();
		write_reg(CFG_BIT_PERIOD, 32'd2);
		finish_frames();
	endtask

	// LED count saturation, last index, count lowered mid-frame, zero LEDs
	task automatic test_led_count();
		quiesce();
		write_reg(CFG_LED_COUNT, 32'd127);
		write_reg(CFG_HIGH_ZERO, 32'd0);
		write_reg(CFG_HIGH_ONE, 32'd1);
		write_reg(CFG_BIT_PERIOD, 32'd1);
		send_item(MODE_SET_ALL, 6'd0, 8'h0F, 8'hF0, 8'h3C);
		send_item(MODE_SET_ONE, 6'd63, 8'hFF, 8'hFF, 8'hFF);
		start_frame();
		repeat (30) push_tick();
		quiesce();
		write_reg(CFG_LED_COUNT, 32'd2);
		finish_frames();
		quiesce();
		write_reg(CFG_LED_COUNT, 32'd0);
		send_item(MODE_SET_ALL, 6'd5, 8'hAA, 8'h55, 8'hAA);
		send_item(MODE_SET_ONE, 6'd0, 8'h55, 8'hAA, 8'h55);
		finish_frames();
		repeat (5) push_tick();
	endtask

	// Phases of random items, each under a fresh random register setting
	task automatic test_random_traffic(input int total, input bit idling);
		int sent;
		int len;
		int phase;
		int cnt;
		int bp;
		int hz;
		int ho;
		int r;
		int n;
		logic [LED_IDX_W-1:0] idx;
		sent = 0;
		phase = 0;
		while (sent < total) begin
			quiesce();
			tx_idle = idling && ($urandom_range(0, 3) != 0);
			rx_idle = idling && ($urandom_range(0, 3) != 0);
			bp = $urandom_range(0, 5);
			case ($urandom_range(0, 9))
				0: cnt = 0;
				1: cnt = $urandom_range(64, 127);
				default: cnt = $urandom_range(1, 4);
			endcase
			// keep big strips quick on the wire
			if (cnt > 4)
				bp = $urandom_range(0, 1);
			hz = $urandom_range(0, bp + 1);
			ho = ($urandom_range(0, 7) == 0) ? 32'hFFFF : $urandom_range(0, bp + 2);
			// upper data bits beyond each register are don't-care
			write_reg(CFG_LED_COUNT, ($urandom & 32'hFFFF_FF80) | cnt);
			write_reg(CFG_HIGH_ZERO, ($urandom & 32'hFFFF_0000) | hz);
			write_reg(CFG_HIGH_ONE, ($urandom & 32'hFFFF_0000) | ho);
			write_reg(CFG_BIT_PERIOD, ($urandom & 32'hFFFF_0000) | bp);
			write_reg(CFG_FRAME_PERIOD, $urandom_range(0, 12));
			len = $urandom_range(60, 160);
			// back up the output so the input stalls while items keep coming
			if (idling && phase == 0)
				rx_hold = 400;
			for (int k = 0; k < len; k++) begin
				if (idling && phase == 1 && k == len / 2)
					settle();
				r = $urandom_range(0, 99);
				n = eff_count();
				if (r < 78) begin
					push_tick();
				end else if (r < 90) begin
					if (n > 0 && $urandom_range(0, 3) != 0)
						idx = LED_IDX_W'($urandom_range(0, n - 1));
					else
						idx = LED_IDX_W'($urandom);
					send_item(MODE_SET_ONE, idx, 8'($urandom), 8'($urandom), 8'($urandom));
				end else if (r < 95) begin
					send_item(MODE_SET_ALL, LED_IDX_W'($urandom), 8'($urandom), 8'($urandom),
						8'($urandom));
				end else begin
					send_item(MODE_NONE, LED_IDX_W'($urandom), 8'($urandom), 8'($urandom),
						8'($urandom));
				end
			end
			sent += len;
			phase++;
		end
	endtask

	// Largest frame period: one frame, then the timer just counts down
	task automatic test_frame_period_max();
		quiesce();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		write_reg(CFG_FRAME_PERIOD, 32'hFFFF_FFFF);
		write_reg(CFG_LED_COUNT, 32'd1);
		write_reg(CFG_BIT_PERIOD, 32'd2);
		write_reg(CFG_HIGH_ZERO, 32'hFFFF);
		write_reg(CFG_HIGH_ONE, 32'd1);
		send_item(MODE_SET_ONE, 6'd0, 8'($urandom), 8'($urandom), 8'($urandom));
		finish_frames();
		repeat (20) push_tick();
	endtask

	// Receiver: long hold on request, random stalls otherwise
	always begin : rx_side
		int stall;
		@(posedge clk);
		if (rx_hold > 0) begin
			stall = rx_hold;
			rx_hold = 0;
			out_ready <= 1'b0;
			repeat (stall) @(posedge clk);
		end else if (rx_idle && arst_n && $urandom_range(0, 5) == 0) begin
			out_ready <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		out_ready <= 1'b1;
	end

	// Compare each taken result with the oldest expectation
	always @(posedge clk) begin
		strip_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (level_q.size() == 0) begin
				if (errors < MAX_REPORTS)
					$error("unexpected result: line_level=%0b sending=%0b", line_level,
						sending);
				errors++;
			end else begin
				want = level_q.pop_front();
				if (line_level !== want.line_level) begin
					if (errors < MAX_REPORTS)
						$error("line_level: expected %0b, actual %0b", want.line_level,
							line_level);
					errors++;
				end
				if (sending !== want.sending) begin
					if (errors < MAX_REPORTS)
						$error("sending: expected %0b, actual %0b", want.sending, sending);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("** rgb_led_strip_serializer: FAILED **");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_bit_timing();
		test_led_count();
		test_random_traffic(800, 1'b1);
		test_random_traffic(150, 1'b0);
		test_frame_period_max();
		settle();
		repeat (FILL_WAIT) @(posedge clk);
		if (errors == 0)
			$display("** rgb_led_strip_serializer: PASSED **");
		else
			$display("** rgb_led_strip_serializer: FAILED **");
		$finish;
	end

endmodule

// ===== files.f =====
design/rls_pkg.sv
design/rls_pixel_store.sv
design/rgb_led_strip_serializer.sv
test/tb.sv
